@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the list unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define IIDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define IIDL_NEVER(label, cond, msg) \
  `IIDL_ASSERT(label, !(cond), msg)

`endif

@@ hw/rtl/iidl_pkg.sv @@
// types and constants of the indexed insert delete list unit
package iidl_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;
  localparam int OCNT_W  = 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DUMPEMPTY = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_INSERT,
    OP_REMOVE,
    OP_DUMP,
    OP_FILL
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } bk_state_t;

endpackage

@@ hw/rtl/iidl_front.sv @@
// front end: accepts transactions and decodes commands for the queue
module iidl_front (
  input  logic                                start,
  output logic                                busy,
  input  logic [iidl_pkg::CMD_W-1:0]          in_command,
  input  logic [iidl_pkg::POS_W-1:0]          in_position,
  input  logic signed [iidl_pkg::DATA_W-1:0]  in_item_value,
  input  iidl_pkg::q_stat_t                   q_stat,
  output logic                                q_push,
  output iidl_pkg::cmd_t                      q_cmd
);

  logic code_ok;

  always_comb begin
    code_ok = 1'b1;
    q_cmd.position = in_position;
    q_cmd.value = in_item_value;
    case (in_command)
      iidl_pkg::CMD_PUSH:   q_cmd.op = iidl_pkg::OP_PUSH;
      iidl_pkg::CMD_POP:    q_cmd.op = iidl_pkg::OP_POP;
      iidl_pkg::CMD_INSERT: q_cmd.op = iidl_pkg::OP_INSERT;
      iidl_pkg::CMD_REMOVE: q_cmd.op = iidl_pkg::OP_REMOVE;
      iidl_pkg::CMD_DUMP:   q_cmd.op = iidl_pkg::OP_DUMP;
      iidl_pkg::CMD_FILL:   q_cmd.op = iidl_pkg::OP_FILL;
      default: begin
        code_ok = 1'b0;
        q_cmd.op = iidl_pkg::OP_PUSH;
      end
    endcase
  end

  assign busy = q_stat.full;
  assign q_push = start && !q_stat.full && code_ok;

endmodule

@@ hw/rtl/iidl_queue.sv @@
// command queue between front end and back end
`include "assert_macros.svh"

module iidl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  iidl_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output iidl_pkg::cmd_t    head_cmd,
  output iidl_pkg::q_stat_t stat
);

  iidl_pkg::cmd_t                  entries_r [iidl_pkg::QUEUE_DEPTH];
  logic [iidl_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [iidl_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [iidl_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  localparam logic [iidl_pkg::QCNT_W-1:0] QFULL = iidl_pkg::QCNT_W'(iidl_pkg::QUEUE_DEPTH);
  localparam logic [iidl_pkg::QPTR_W-1:0] QLAST =
    iidl_pkg::QPTR_W'(iidl_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QLAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QLAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd = entries_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full = (cnt_r == QFULL);

  `IIDL_NEVER(a_q_overflow, push && stat.full, "queue push while full")
  `IIDL_NEVER(a_q_underflow, pop && stat.empty, "queue pop while empty")
  `IIDL_ASSERT(a_q_count, (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1, "queue count slip")

endmodule

@@ hw/rtl/iidl_back.sv @@
// back end: element cells, command execution and result register
`include "assert_macros.svh"

module iidl_back #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iidl_pkg::cmd_t                      head_cmd,
  input  iidl_pkg::q_stat_t                   q_stat,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic [iidl_pkg::STAT_W-1:0]         out_status,
  output logic signed [iidl_pkg::DATA_W-1:0]  out_element,
  output logic [iidl_pkg::OCNT_W-1:0]         out_element_count,
  output logic                                out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [iidl_pkg::OCNT_W-1:0] CAP7 = iidl_pkg::OCNT_W'(CAPACITY);

  logic signed [iidl_pkg::DATA_W-1:0] cells_r [CAPACITY];

  iidl_pkg::bk_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    rd_idx;

  logic                               valid_r, valid_nxt;
  logic [iidl_pkg::STAT_W-1:0]        status_r, status_nxt;
  logic signed [iidl_pkg::DATA_W-1:0] element_r, element_nxt;
  logic [iidl_pkg::OCNT_W-1:0]        ecount_r, ecount_nxt;
  logic                               last_r, last_nxt;

  logic [iidl_pkg::OCNT_W-1:0] cnt7, pos7;
  logic                        take, dump_last;
  logic                        do_push, do_insert, do_remove, do_fill;
  logic signed [iidl_pkg::DATA_W-1:0] wval;

  assign cnt7 = iidl_pkg::OCNT_W'(count_r);
  assign pos7 = iidl_pkg::OCNT_W'(head_cmd.position);
  assign wval = head_cmd.value;
  assign take = (state_r == iidl_pkg::BK_IDLE) && !q_stat.empty;
  assign q_pop = take;
  assign rd_idx = (state_r == iidl_pkg::BK_DUMP) ? idx_r : '0;
  assign dump_last = (iidl_pkg::OCNT_W'(rd_idx) + 1'b1) == cnt7;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iidl_pkg::BK_IDLE: begin
        if (take && head_cmd.op == iidl_pkg::OP_DUMP && cnt7 != '0 && !dump_last) begin
          state_nxt = iidl_pkg::BK_DUMP;
        end
      end
      iidl_pkg::BK_DUMP: begin
        if (dump_last) begin
          state_nxt = iidl_pkg::BK_IDLE;
        end
      end
      default: state_nxt = iidl_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    count_nxt = count_r;
    idx_nxt = idx_r;
    valid_nxt = 1'b0;
    status_nxt = iidl_pkg::STAT_OK;
    element_nxt = '0;
    last_nxt = 1'b1;
    do_push = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_fill = 1'b0;
    case (state_r)
      iidl_pkg::BK_IDLE: begin
        if (take) begin
          valid_nxt = 1'b1;
          case (head_cmd.op)
            iidl_pkg::OP_PUSH: begin
              if (cnt7 >= CAP7) begin
                status_nxt = iidl_pkg::STAT_FULL;
              end else begin
                do_push = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            iidl_pkg::OP_POP: begin
              if (cnt7 == '0) begin
                status_nxt = iidl_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            iidl_pkg::OP_INSERT: begin
              if (pos7 > cnt7) begin
                status_nxt = iidl_pkg::STAT_BADPOS;
              end else if (cnt7 >= CAP7) begin
                status_nxt = iidl_pkg::STAT_FULL;
              end else begin
                do_insert = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            iidl_pkg::OP_REMOVE: begin
              if (cnt7 == '0) begin
                status_nxt = iidl_pkg::STAT_EMPTY;
              end else if (pos7 >= cnt7) begin
                status_nxt = iidl_pkg::STAT_BADPOS;
              end else begin
                do_remove = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            iidl_pkg::OP_DUMP: begin
              if (cnt7 == '0) begin
                status_nxt = iidl_pkg::STAT_DUMPEMPTY;
              end else begin
                element_nxt = cells_r[rd_idx];
                last_nxt = dump_last;
                idx_nxt = IDX_W'(1);
              end
            end
            iidl_pkg::OP_FILL: begin
              if (pos7 > CAP7) begin
                status_nxt = iidl_pkg::STAT_FULL;
              end else begin
                do_fill = 1'b1;
                count_nxt = CNT_W'(pos7);
              end
            end
            default: valid_nxt = 1'b0;
          endcase
        end
      end
      iidl_pkg::BK_DUMP: begin
        valid_nxt = 1'b1;
        element_nxt = cells_r[rd_idx];
        last_nxt = dump_last;
        idx_nxt = idx_r + 1'b1;
      end
      default: valid_nxt = 1'b0;
    endcase
    ecount_nxt = iidl_pkg::OCNT_W'(count_nxt);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [iidl_pkg::OCNT_W-1:0] IDX = iidl_pkg::OCNT_W'(g);
    logic signed [iidl_pkg::DATA_W-1:0] below, above, cell_nxt;
    logic                               cell_we;

    if (g == 0) begin : g_lo
      assign below = cells_r[0];
    end else begin : g_lo
      assign below = cells_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign above = cells_r[g];
    end else begin : g_hi
      assign above = cells_r[g+1];
    end

    always_comb begin
      cell_we = 1'b0;
      cell_nxt = wval;
      if (do_push && IDX == cnt7) begin
        cell_we = 1'b1;
      end else if (do_insert && IDX == pos7) begin
        cell_we = 1'b1;
      end else if (do_insert && IDX > pos7 && IDX <= cnt7) begin
        cell_we = 1'b1;
        cell_nxt = below;
      end else if (do_remove && IDX >= pos7 && (IDX + 1'b1) < cnt7) begin
        cell_we = 1'b1;
        cell_nxt = above;
      end else if (do_fill && IDX < pos7) begin
        cell_we = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (cell_we) begin
        cells_r[g] <= cell_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iidl_pkg::BK_IDLE;
      count_r <= '0;
      idx_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    element_r <= element_nxt;
    ecount_r <= ecount_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_status = status_r;
  assign out_element = element_r;
  assign out_element_count = ecount_r;
  assign out_last = last_r;

  `IIDL_ASSERT(a_count_cap, iidl_pkg::OCNT_W'(count_r) <= CAP7, "count above capacity")
  `IIDL_ASSERT(a_dump_nonempty, (state_r == iidl_pkg::BK_DUMP) |-> count_r != '0, "dump of empty list")
  `IIDL_ASSERT(a_dump_hold, (state_r == iidl_pkg::BK_DUMP) |-> !q_pop && $stable(count_r), "edit during dump")

endmodule

@@ hw/rtl/indexed_insert_delete_list_unit.sv @@
// top level of the indexed insert delete list unit
//
// ordered list of signed 32-bit elements, CAPACITY entries deep, with a count.
// input channel: a transaction is taken at a clock edge with start high and
// busy low; in_command selects push, pop, insert, remove, dump or fill, and
// codes 6 and 7 are dropped without a result.
// a two-entry command queue sits between the front end and the back end;
// busy is high only while that queue is full.
// result channel: out_valid marks each result for exactly one cycle; the
// receiver cannot stall it, so no result waits.
// with the queue empty and the back end idle, a taken transaction is written
// into the queue, the back end takes it from the queue head, and the first
// result of its command goes through the result register to the result ports.
// the back end finishes each command before it takes the next; edits use the
// per-cell shift muxes, and a dump returns the stored elements one by one (a
// single result for an empty list) by the single read port of the cell array.
// reset: rst_n low clears the count (empty list), the queue and the result
// strobe; element cells are not cleared.
module indexed_insert_delete_list_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [iidl_pkg::CMD_W-1:0]          in_command,
  input  logic [iidl_pkg::POS_W-1:0]          in_position,
  input  logic signed [iidl_pkg::DATA_W-1:0]  in_item_value,
  output logic                                out_valid,
  output logic [iidl_pkg::STAT_W-1:0]         out_status,
  output logic signed [iidl_pkg::DATA_W-1:0]  out_element,
  output logic [iidl_pkg::OCNT_W-1:0]         out_element_count,
  output logic                                out_last
);

  iidl_pkg::q_stat_t q_stat;
  iidl_pkg::cmd_t    push_cmd, head_cmd;
  logic              q_push, q_pop;

  iidl_front u_front (
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  iidl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  iidl_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_cmd          (head_cmd),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_count (out_element_count),
    .out_last          (out_last)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench for the indexed insert delete list unit: directed table, then random commands
module tb;

  localparam int CAPACITY = 16;
  localparam logic [iidl_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [iidl_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [iidl_pkg::STAT_W-1:0] status;
    logic [iidl_pkg::DATA_W-1:0] element;
    logic [iidl_pkg::OCNT_W-1:0] count;
    logic                        last;
  } list_result_t;

  typedef struct packed {
    logic [iidl_pkg::CMD_W-1:0]  command;
    logic [iidl_pkg::POS_W-1:0]  position;
    logic [iidl_pkg::DATA_W-1:0] value;
    logic                        typed;
    logic [iidl_pkg::STAT_W-1:0] status;
    logic [iidl_pkg::OCNT_W-1:0] count;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [iidl_pkg::CMD_W-1:0] in_command = '0;
  logic [iidl_pkg::POS_W-1:0] in_position = '0;
  logic signed [iidl_pkg::DATA_W-1:0] in_item_value = '0;
  logic out_valid;
  logic [iidl_pkg::STAT_W-1:0] out_status;
  logic signed [iidl_pkg::DATA_W-1:0] out_element;
  logic [iidl_pkg::OCNT_W-1:0] out_element_count;
  logic out_last;

  logic signed [iidl_pkg::DATA_W-1:0] predicted_elems [CAPACITY];
  int predicted_len = 0;
  list_result_t pending_results [$];
  int fail_count = 0;

  directed_row_t directed_rows [26] = '{
    '{iidl_pkg::CMD_POP,    6'd0,  32'h0,        1'b1, iidl_pkg::STAT_EMPTY,     7'd0},
    '{iidl_pkg::CMD_REMOVE, 6'd0,  32'h0,        1'b1, iidl_pkg::STAT_EMPTY,     7'd0},
    '{iidl_pkg::CMD_DUMP,   6'd0,  32'h0,        1'b1, iidl_pkg::STAT_DUMPEMPTY, 7'd0},
    '{iidl_pkg::CMD_INSERT, 6'd1,  32'h1234,     1'b1, iidl_pkg::STAT_BADPOS,    7'd0},
    '{iidl_pkg::CMD_INSERT, 6'd0,  32'h7fffffff, 1'b1, iidl_pkg::STAT_OK,        7'd1},
    '{iidl_pkg::CMD_PUSH,   6'd0,  32'h80000000, 1'b1, iidl_pkg::STAT_OK,        7'd2},
    '{iidl_pkg::CMD_INSERT, 6'd1,  32'hffffffff, 1'b1, iidl_pkg::STAT_OK,        7'd3},
    '{iidl_pkg::CMD_DUMP,   6'd0,  32'h0,        1'b0, iidl_pkg::STAT_OK,        7'd0},
    '{iidl_pkg::CMD_REMOVE, 6'd3,  32'h0,        1'b1, iidl_pkg::STAT_BADPOS,    7'd3},
    '{iidl_pkg::CMD_REMOVE, 6'd0,  32'h0,        1'b1, iidl_pkg::STAT_OK,        7'd2},
    '{iidl_pkg::CMD_FILL,   6'd16, 32'h5a5a5a5a, 1'b1, iidl_pkg::STAT_OK,        7'd16},
    '{iidl_pkg::CMD_PUSH,   6'd0,  32'h1,        1'b1, iidl_pkg::STAT_FULL,      7'd16},
    '{iidl_pkg::CMD_INSERT, 6'd16, 32'h2,        1'b1, iidl_pkg::STAT_FULL,      7'd16},
    '{iidl_pkg::CMD_INSERT, 6'd17, 32'h3,        1'b1, iidl_pkg::STAT_BADPOS,    7'd16},
    '{iidl_pkg::CMD_INSERT, 6'd63, 32'h4,        1'b1, iidl_pkg::STAT_BADPOS,    7'd16},
    '{iidl_pkg::CMD_FILL,   6'd17, 32'h5,        1'b1, iidl_pkg::STAT_FULL,      7'd16},
    '{iidl_pkg::CMD_FILL,   6'd63, 32'h6,        1'b1, iidl_pkg::STAT_FULL,      7'd16},
    '{iidl_pkg::CMD_REMOVE, 6'd15, 32'h0,        1'b1, iidl_pkg::STAT_OK,        7'd15},
    '{iidl_pkg::CMD_INSERT, 6'd0,  32'ha5a5a5a5, 1'b1, iidl_pkg::STAT_OK,        7'd16},
    '{iidl_pkg::CMD_DUMP,   6'd0,  32'h0,        1'b0, iidl_pkg::STAT_OK,        7'd0},
    '{CMD_RSVD6,            6'd63, 32'hffffffff, 1'b0, iidl_pkg::STAT_OK,        7'd0},
    '{CMD_RSVD7,            6'd42, 32'h0f0f0f0f, 1'b0, iidl_pkg::STAT_OK,        7'd0},
    '{iidl_pkg::CMD_FILL,   6'd0,  32'h77,       1'b1, iidl_pkg::STAT_OK,        7'd0},
    '{iidl_pkg::CMD_POP,    6'd0,  32'h0,        1'b1, iidl_pkg::STAT_EMPTY,     7'd0},
    '{iidl_pkg::CMD_FILL,   6'd1,  32'h0,        1'b1, iidl_pkg::STAT_OK,        7'd1},
    '{iidl_pkg::CMD_DUMP,   6'd0,  32'h0,        1'b0, iidl_pkg::STAT_OK,        7'd0}
  };

  indexed_insert_delete_list_unit #(.CAPACITY(CAPACITY)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_count (out_element_count),
    .out_last          (out_last)
  );

  always #1 clk = ~clk;

  function automatic void push_result(logic [iidl_pkg::STAT_W-1:0] status,
                                      logic [iidl_pkg::DATA_W-1:0] element,
                                      logic last);
    list_result_t r;
    r.status = status;
    r.element = element;
    r.count = iidl_pkg::OCNT_W'(predicted_len);
    r.last = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  task automatic apply_list_command(input logic [iidl_pkg::CMD_W-1:0] cmd,
                                    input logic [iidl_pkg::POS_W-1:0] pos,
                                    input logic [iidl_pkg::DATA_W-1:0] val);
    logic [iidl_pkg::STAT_W-1:0] status;
    int p;
    status = iidl_pkg::STAT_OK;
    p = int'(pos);
    case (cmd)
      iidl_pkg::CMD_PUSH: begin
        if (predicted_len >= CAPACITY) begin
          status = iidl_pkg::STAT_FULL;
        end else begin
          predicted_elems[predicted_len] = val;
          predicted_len++;
        end
      end
      iidl_pkg::CMD_POP: begin
        if (predicted_len == 0) status = iidl_pkg::STAT_EMPTY;
        else predicted_len--;
      end
      iidl_pkg::CMD_INSERT: begin
        if (p > predicted_len) begin
          status = iidl_pkg::STAT_BADPOS;
        end else if (predicted_len >= CAPACITY) begin
          status = iidl_pkg::STAT_FULL;
        end else begin
          for (int i = predicted_len; i > p; i--) predicted_elems[i] = predicted_elems[i-1];
          predicted_elems[p] = val;
          predicted_len++;
        end
      end
      iidl_pkg::CMD_REMOVE: begin
        if (predicted_len == 0) begin
          status = iidl_pkg::STAT_EMPTY;
        end else if (p >= predicted_len) begin
          status = iidl_pkg::STAT_BADPOS;
        end else begin
          for (int i = p; i + 1 < predicted_len; i++) predicted_elems[i] = predicted_elems[i+1];
          predicted_len--;
        end
      end
      iidl_pkg::CMD_DUMP: begin
        if (predicted_len == 0) begin
          push_result(iidl_pkg::STAT_DUMPEMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < predicted_len; i++)
            push_result(iidl_pkg::STAT_OK, predicted_elems[i], i + 1 == predicted_len);
        end
        return;
      end
      iidl_pkg::CMD_FILL: begin
        if (p > CAPACITY) begin
          status = iidl_pkg::STAT_FULL;
        end else begin
          predicted_len = p;
          for (int i = 0; i < p; i++) predicted_elems[i] = val;
        end
      end
      default: return;
    endcase
    push_result(status, '0, 1'b1);
  endtask

  task automatic send_command(input logic [iidl_pkg::CMD_W-1:0] cmd,
                              input logic [iidl_pkg::POS_W-1:0] pos,
                              input logic [iidl_pkg::DATA_W-1:0] val);
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    apply_list_command(cmd, pos, val);
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [iidl_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int items, input int idle_pct);
    int sent;
    int pick;
    logic [iidl_pkg::CMD_W-1:0] cmd;
    logic [iidl_pkg::POS_W-1:0] pos;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      pos = iidl_pkg::POS_W'($urandom_range(0, 63));
      if (pick < 25) begin
        cmd = iidl_pkg::CMD_PUSH;
      end else if (pick < 37) begin
        cmd = iidl_pkg::CMD_POP;
      end else if (pick < 57) begin
        cmd = iidl_pkg::CMD_INSERT;
        if ($urandom_range(0, 4) != 0)
          pos = iidl_pkg::POS_W'($urandom_range(0, predicted_len));
      end else if (pick < 72) begin
        cmd = iidl_pkg::CMD_REMOVE;
        if ($urandom_range(0, 4) != 0 && predicted_len > 0)
          pos = iidl_pkg::POS_W'($urandom_range(0, predicted_len - 1));
      end else if (pick < 84) begin
        cmd = iidl_pkg::CMD_DUMP;
      end else if (pick < 96) begin
        cmd = iidl_pkg::CMD_FILL;
        if ($urandom_range(0, 3) != 0) pos = iidl_pkg::POS_W'($urandom_range(0, CAPACITY));
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
      end
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        idle_sender($urandom_range(1, idle_pct > 50 ? 5 : 2));
      send_command(cmd, pos, random_value());
      if (cmd != CMD_RSVD6 && cmd != CMD_RSVD7) sent++;
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d element %0d count %0d",
               out_status, out_element, out_element_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_element !== want.element) begin
          $error("element mismatch: expected %0d, actual %0d",
                 $signed(want.element), out_element);
          fail_count++;
        end
        if (out_element_count !== want.count) begin
          $error("element_count mismatch: expected %0d, actual %0d",
                 want.count, out_element_count);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    list_result_t r;
    int tail;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 3));
      send_command(directed_rows[i].command, directed_rows[i].position, directed_rows[i].value);
      if (directed_rows[i].typed) begin
        tail = pending_results.size() - 1;
        r = pending_results[tail];
        r.status = directed_rows[i].status;
        r.count = directed_rows[i].count;
        r.element = '0;
        r.last = 1'b1;
        pending_results[tail] = r;
      end
    end
    drain_results();

    random_phase(ITEMS_PER_PHASE, 24);
    drain_results();
    random_phase(ITEMS_PER_PHASE, 70);
    drain_results();
    random_phase(ITEMS_PER_PHASE, 0);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
